// ----- src/swm_pkg.sv -----
// Shared constants, types and helpers of the sliding window maximum block.
package swm_pkg;

   // Window storage depth and derived widths
   localparam int WIN_MAX = 64;
   localparam int IDX_W   = $clog2(WIN_MAX);
   localparam int CNT_W   = $clog2(WIN_MAX + 1);
   localparam int DATA_W  = 32;
   localparam int WLEN_W  = 7;

   // Register port
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-1:0] CSR_WLEN_ADDR = 2'd0;
   localparam logic [WLEN_W-1:0] WLEN_RESET    = 7'd3;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [WLEN_W-1:0]        wlen_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;      // item taken this cycle
      logic start_scan;  // item gives a result: arm the history scan
      logic scan;        // scan in progress
      logic load_out;    // move the finished maximum to the output register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic has_result;  // the offered item completes a window
      logic scan_done;   // all history reads issued and compared
      logic out_free;    // output register can take a result this cycle
   } ctrl_status_type;

   // Window length as used: zero counts as one, clipped to the storage depth
   function automatic cnt_type eff_window(input wlen_type wl);
      cnt_type res;
      if (wl == '0) begin
         res = cnt_type'(1);
      end else if (int'(wl) > WIN_MAX) begin
         res = cnt_type'(WIN_MAX);
      end else begin
         res = cnt_type'(wl);
      end
      return res;
   endfunction

endpackage

// ----- src/swm_req_if.sv -----
// Input channel: one sample item with its end-of-sequence flag.
interface swm_req_if;
   import swm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last_of_sequence;

   modport source (output valid, output sample, output last_of_sequence, input ready);
   modport sink   (input valid, input sample, input last_of_sequence, output ready);
endinterface

// ----- src/swm_rsp_if.sv -----
// Result channel: window maximum with its final mark.
interface swm_rsp_if;
   import swm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type window_max;
   logic       is_final;

   modport source (output valid, output window_max, output is_final, input ready);
   modport sink   (input valid, input window_max, input is_final, output ready);
endinterface

// ----- src/sliding_window_maximum_top.sv -----
// Top level of the sliding window maximum block: channels, register port, units.
//
// Usage:
//   req_ch carries one signed 32-bit sample item with a last_of_sequence flag.
//   Each item that brings the current sequence to window_len samples or more
//   gives one item on rsp_ch: the maximum of the latest window_len samples,
//   with is_final set on the result of the sequence's last sample. A sequence
//   shorter than the window gives nothing; the last item clears the sequence.
//   window_len is written over the APB-style port at byte address 0; zero is
//   taken as 1 and values above 64 as 64. Write it only while idle.
// Steps:
//   An item that gives no result is only stored. An item that gives a result
//   is taken, then one history read per older sample of the window is made
//   and compared, and the maximum is loaded into the output register.
//   The result shows on rsp_ch from the cycle after that load.
// Reset: synchronous, clears the sequence; window_len returns to 3.
// Stall: a result waits in the output register; the next item is still taken
//   and scanned, but no item is taken while a scan is in progress, and a
//   scan whose result is ready waits while the previous one has not been taken.
module sliding_window_maximum_top
   import swm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   swm_req_if.sink           req_ch,
   swm_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   wlen_type        window_len_ff;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            csr_wr;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == CSR_WLEN_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WLEN_RESET;
      end else if (csr_wr) begin
         window_len_ff <= csr_pwdata[WLEN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_WLEN_ADDR) begin
         csr_prdata = {{(CSR_DW-WLEN_W){1'b0}}, window_len_ff};
      end
   end

   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   swm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .window_len       (window_len_ff),
      .sample           (req_ch.sample),
      .last_of_sequence (req_ch.last_of_sequence),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .window_max       (rsp_ch.window_max),
      .is_final         (rsp_ch.is_final)
   );

endmodule

// ----- src/swm_ctrl.sv -----
// Controller state machine: takes items and sequences the history scan.
module swm_ctrl
   import swm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff, state_in;

   // Commands
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd.accept     = req_valid && req_ready;
      cmd.start_scan = cmd.accept && status.has_result;
      cmd.scan       = (state_ff == ST_SCAN);
      cmd.load_out   = (state_ff == ST_SCAN) && status.scan_done && status.out_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start_scan) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cmd.load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/swm_datapath.sv -----
// Datapath: sample history memory, sequence counters, max scan and output register.
module swm_datapath
   import swm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   input  wlen_type        window_len,
   input  sample_type      sample,
   input  logic            last_of_sequence,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output sample_type      window_max,
   output logic            is_final
);

   // History of the latest samples, indexed by position modulo the depth
   sample_type hist_mem [WIN_MAX];

   idx_type    wr_ptr_ff, wr_ptr_in;
   cnt_type    seen_ff, seen_in, seen_next;
   idx_type    issue_cnt_ff;
   idx_type    rd_addr_ff;
   logic       rd_vld_ff;
   sample_type rd_data_ff;
   sample_type max_ff;
   logic       last_ff;
   logic       out_valid_ff;
   sample_type out_max_ff;
   logic       out_final_ff;
   cnt_type    win;

   // Sequence bookkeeping
   always_comb begin
      win       = eff_window(window_len);
      seen_next = (seen_ff < cnt_type'(WIN_MAX)) ? seen_ff + cnt_type'(1) : seen_ff;
      seen_in   = last_of_sequence ? '0 : seen_next;
      wr_ptr_in = last_of_sequence ? '0 : wr_ptr_ff + idx_type'(1);
   end

   assign status.has_result = (seen_next >= win);
   assign status.scan_done  = (issue_cnt_ff == '0) && !rd_vld_ff;
   assign status.out_free   = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         seen_ff   <= '0;
      end else if (cmd.accept) begin
         wr_ptr_ff <= wr_ptr_in;
         seen_ff   <= seen_in;
      end
   end

   // History write on accept
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hist_mem[wr_ptr_ff] <= sample;
      end
   end

   // Scan read port: one older sample a cycle, data registered
   always_ff @(posedge clock) begin
      if (cmd.scan && issue_cnt_ff != '0) begin
         rd_data_ff <= hist_mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else if (cmd.start_scan) begin
         issue_cnt_ff <= idx_type'(win - cnt_type'(1));
         rd_vld_ff    <= 1'b0;
      end else if (cmd.scan && issue_cnt_ff != '0) begin
         issue_cnt_ff <= issue_cnt_ff - idx_type'(1);
         rd_vld_ff    <= 1'b1;
      end else begin
         rd_vld_ff    <= 1'b0;
      end
   end

   // Read address walks back from the newest stored sample
   always_ff @(posedge clock) begin
      if (cmd.start_scan) begin
         rd_addr_ff <= wr_ptr_ff - idx_type'(1);
      end else if (cmd.scan && issue_cnt_ff != '0) begin
         rd_addr_ff <= rd_addr_ff - idx_type'(1);
      end
   end

   // Running maximum, seeded with the new sample
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         max_ff  <= sample;
         last_ff <= last_of_sequence;
      end else if (rd_vld_ff && (rd_data_ff > max_ff)) begin
         max_ff  <= rd_data_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_max_ff   <= max_ff;
         out_final_ff <= last_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign window_max = out_max_ff;
   assign is_final   = out_final_ff;

`ifndef ASSERT_OFF
   a_rd_from_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(cmd.scan))
      else $error("history read data valid without a scan issue");

   a_load_when_done: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (issue_cnt_ff == '0) && !rd_vld_ff)
      else $error("result loaded before the scan finished");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (issue_cnt_ff == '0) && !rd_vld_ff)
      else $error("item accepted during a scan");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= cnt_type'(WIN_MAX))
      else $error("sample count beyond storage depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !cmd.load_out)
      else $error("pending result overwritten");
`endif

endmodule
